@@ src/i2cbm_pkg.sv @@
// shared types, constants and phase tables of the i2c bit-level master
package i2cbm_pkg;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_STOP  = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef enum logic {
    ENG_IDLE = 1'b0,
    ENG_BUSY = 1'b1
  } eng_state_t;

  typedef struct packed {
    logic       has_cmd;
    mode_t      mode;
    logic [7:0] tx_byte;
    logic       send_nack;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rx_byte;
    logic       ack;
  } res_t;

  localparam int          ITEM_W          = $bits(item_t);
  localparam int          RES_W           = $bits(res_t);
  localparam int          QUEUE_DEPTH_DEF = 2;
  localparam logic [15:0] PHASE_TICKS_RST = 16'd100;
  localparam logic [7:0]  MSB_MASK        = 8'h80;

  localparam int PHASE_W = 5;
  localparam int TICK_W  = 16;

  // write sequence landmarks
  localparam logic [PHASE_W-1:0] WR_REL_SDA  = 5'd24;
  localparam logic [PHASE_W-1:0] WR_ACK_LOW  = 5'd25;
  localparam logic [PHASE_W-1:0] WR_ACK_HIGH = 5'd26;
  localparam logic [PHASE_W-1:0] WR_ACK_SAMP = 5'd27;

  // read sequence landmarks
  localparam logic [PHASE_W-1:0] RD_REL_SDA  = 5'd0;
  localparam logic [PHASE_W-1:0] RD_SCL_LOW  = 5'd1;
  localparam logic [PHASE_W-1:0] RD_BITS_END = 5'd18;
  localparam logic [PHASE_W-1:0] RD_ACK_DRV  = 5'd18;
  localparam logic [PHASE_W-1:0] RD_ACK_HIGH = 5'd19;
  localparam logic [PHASE_W-1:0] RD_ACK_LOW  = 5'd20;

  localparam logic [1:0] SUB_SETUP = 2'd0;
  localparam logic [1:0] SUB_HIGH  = 2'd1;
  localparam logic [1:0] SUB_SHIFT = 2'd2;

  function automatic logic [PHASE_W-1:0] phase_total(input mode_t m);
    logic [PHASE_W-1:0] n;
    unique case (m)
      MODE_START: n = 5'd2;
      MODE_STOP:  n = 5'd3;
      MODE_WRITE: n = 5'd29;
      MODE_READ:  n = 5'd22;
      default:    n = 5'd2;
    endcase
    return n;
  endfunction

endpackage

@@ src/i2cbm_fifo.sv @@
// small word queue between the front, the bus engine and the result side
module i2cbm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ src/i2cbm_front.sv @@
// input side: accepts tick words and decodes the command they carry
module i2cbm_front (
  input  logic                 push,
  output logic                 full,
  input  logic                 in_cmd_valid,
  input  logic [1:0]           in_mode,
  input  logic [7:0]           in_tx_byte,
  input  logic                 in_send_nack,
  input  logic                 in_sda_in,
  input  logic                 q_full,
  output logic                 q_wr,
  output i2cbm_pkg::item_t     q_item
);
  import i2cbm_pkg::*;

  mode_t mode_dec;

  assign full     = q_full;
  assign q_wr     = push;
  assign mode_dec = mode_t'(in_mode);

  always_comb begin
    q_item.has_cmd   = in_cmd_valid;
    q_item.mode      = mode_dec;
    // payload only matters for the commands that use it
    q_item.tx_byte   = (in_cmd_valid && mode_dec == MODE_WRITE) ? in_tx_byte : '0;
    q_item.send_nack = (in_cmd_valid && mode_dec == MODE_READ) ? in_send_nack : 1'b0;
    q_item.sda_in    = in_sda_in;
  end

endmodule

@@ src/i2cbm_engine.sv @@
// bus engine: runs start, stop, write and read phase sequences one tick at a time
module i2cbm_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [15:0]       phase_ticks,
  input  logic              q_empty,
  input  i2cbm_pkg::item_t  q_item,
  output logic              q_rd,
  input  logic              r_full,
  output logic              r_wr,
  output i2cbm_pkg::res_t   r_res
);
  import i2cbm_pkg::*;

  eng_state_t         state_r, state_nxt;
  mode_t              mode_r, mode_nxt;
  logic [PHASE_W-1:0] idx_r, idx_nxt;
  logic [TICK_W-1:0]  tick_r, tick_nxt;
  logic [1:0]         sub_r, sub_nxt;
  logic [7:0]         shift_r, shift_nxt;
  logic               nack_r, nack_nxt;
  logic               scl_r, scl_nxt;
  logic               sda_r, sda_nxt;
  logic [7:0]         rx_r, rx_nxt;
  logic               ack_r, ack_nxt;
  logic               done;

  logic               step;
  logic [TICK_W-1:0]  len;
  logic               phase_end;
  logic [PHASE_W-1:0] idx_inc;
  logic [1:0]         sub_inc;
  logic               seq_end;
  logic               start_cmd;
  logic               enter;

  // phase entry operands
  mode_t              e_mode;
  logic [PHASE_W-1:0] e_p;
  logic [1:0]         e_sub;
  logic [7:0]         e_shift;
  logic               e_nack;
  logic               e_scl, e_sda, e_ack;
  logic [7:0]         e_shift_o;

  assign step      = !q_empty && !r_full;
  assign q_rd      = step;
  assign r_wr      = step;
  assign len       = (phase_ticks == '0) ? TICK_W'(1) : phase_ticks;
  assign phase_end = (tick_r >= len);
  assign idx_inc   = idx_r + 1'b1;
  assign sub_inc   = (sub_r == SUB_SHIFT) ? SUB_SETUP : sub_r + 1'b1;
  assign seq_end   = (idx_inc >= phase_total(mode_r));
  assign start_cmd = (state_r == ENG_IDLE) && q_item.has_cmd;
  assign enter     = start_cmd || ((state_r == ENG_BUSY) && phase_end && !seq_end);

  assign e_mode  = start_cmd ? q_item.mode : mode_r;
  assign e_p     = start_cmd ? '0 : idx_inc;
  assign e_sub   = start_cmd ? SUB_SETUP : sub_inc;
  assign e_shift = start_cmd ? q_item.tx_byte : shift_r;
  assign e_nack  = start_cmd ? q_item.send_nack : nack_r;

  // line actions and sampling of the phase being entered
  always_comb begin
    e_scl     = scl_r;
    e_sda     = sda_r;
    e_ack     = ack_r;
    e_shift_o = e_shift;
    unique case (e_mode)
      MODE_START: begin
        if (e_p == '0) begin
          e_sda = 1'b1;
          e_scl = 1'b1;
        end else begin
          e_sda = 1'b0;
        end
      end
      MODE_STOP: begin
        if (e_p == '0) begin
          e_sda = 1'b0;
        end else if (e_p == PHASE_W'(1)) begin
          e_scl = 1'b1;
        end else begin
          e_sda = 1'b1;
        end
      end
      MODE_WRITE: begin
        if (e_p < WR_REL_SDA) begin
          unique case (e_sub)
            SUB_SETUP: begin
              e_sda = |(e_shift & MSB_MASK);
              e_scl = 1'b0;
            end
            SUB_HIGH: e_scl = 1'b1;
            default: begin
              e_shift_o = {e_shift[6:0], 1'b0};
              e_scl     = 1'b0;
            end
          endcase
        end else if (e_p == WR_REL_SDA) begin
          e_sda = 1'b1;
        end else if (e_p == WR_ACK_LOW) begin
          e_scl = 1'b0;
        end else if (e_p == WR_ACK_HIGH) begin
          e_scl = 1'b1;
        end else if (e_p == WR_ACK_SAMP) begin
          e_ack = q_item.sda_in;
        end else begin
          e_scl = 1'b0;
        end
      end
      MODE_READ: begin
        if (e_p == RD_REL_SDA) begin
          e_sda = 1'b1;
        end else if (e_p == RD_SCL_LOW) begin
          e_scl = 1'b0;
        end else if (e_p < RD_BITS_END) begin
          if (!e_p[0]) begin
            e_scl = 1'b1;
          end else begin
            e_shift_o = {e_shift[6:0], q_item.sda_in};
            e_scl     = 1'b0;
          end
        end else if (e_p == RD_ACK_DRV) begin
          e_sda = e_nack;
        end else if (e_p == RD_ACK_HIGH) begin
          e_scl = 1'b1;
        end else if (e_p == RD_ACK_LOW) begin
          e_scl = 1'b0;
        end else begin
          e_sda = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ENG_IDLE: if (q_item.has_cmd) state_nxt = ENG_BUSY;
      ENG_BUSY: if (phase_end && seq_end) state_nxt = ENG_IDLE;
      default:  state_nxt = ENG_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    mode_nxt  = mode_r;
    idx_nxt   = idx_r;
    tick_nxt  = tick_r;
    sub_nxt   = sub_r;
    shift_nxt = shift_r;
    nack_nxt  = nack_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    rx_nxt    = rx_r;
    ack_nxt   = ack_r;
    done      = 1'b0;
    unique case (state_r)
      ENG_IDLE: begin
        if (q_item.has_cmd) begin
          mode_nxt = q_item.mode;
          nack_nxt = q_item.send_nack;
        end
      end
      ENG_BUSY: begin
        if (phase_end) begin
          if (seq_end) begin
            done     = 1'b1;
            idx_nxt  = '0;
            tick_nxt = '0;
            if (mode_r == MODE_READ) begin
              rx_nxt = shift_r;
            end
          end
        end else begin
          tick_nxt = tick_r + 1'b1;
        end
      end
      default: ;
    endcase
    if (enter) begin
      idx_nxt   = e_p;
      sub_nxt   = e_sub;
      tick_nxt  = TICK_W'(1);
      shift_nxt = e_shift_o;
      scl_nxt   = e_scl;
      sda_nxt   = e_sda;
      ack_nxt   = e_ack;
    end
  end

  always_comb begin
    r_res.scl     = scl_nxt;
    r_res.sda     = sda_nxt;
    r_res.busy    = (state_nxt == ENG_BUSY);
    r_res.done    = done;
    r_res.rx_byte = rx_nxt;
    r_res.ack     = ack_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ENG_IDLE;
      mode_r  <= MODE_START;
      idx_r   <= '0;
      tick_r  <= '0;
      sub_r   <= SUB_SETUP;
      shift_r <= '0;
      nack_r  <= 1'b0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      rx_r    <= '0;
      ack_r   <= 1'b1;
    end else if (step) begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      idx_r   <= idx_nxt;
      tick_r  <= tick_nxt;
      sub_r   <= sub_nxt;
      shift_r <= shift_nxt;
      nack_r  <= nack_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      rx_r    <= rx_nxt;
      ack_r   <= ack_nxt;
    end
  end

`ifndef SYNTHESIS
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (step && r_res.done) |-> !r_res.busy)
    else $error("done word reports busy");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ENG_BUSY) |-> (idx_r < phase_total(mode_r)))
    else $error("phase index beyond sequence length");

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ENG_IDLE) |-> (tick_r == '0 && idx_r == '0))
    else $error("idle engine holds phase position");

  a_busy_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ENG_BUSY) |-> (tick_r != '0))
    else $error("busy engine with zero tick count");
`endif

endmodule

@@ src/i2c_bit_level_master_unit.sv @@
// i2c bit-level master: tick input queue, bus engine and result queue
//
// Usage:
//   Each input word is one tick of the bus engine: the sampled SDA level and,
//   while the engine is idle, an optional start, stop, write or read command.
//   Words go in through push/full and every word yields exactly one result
//   word (SCL, SDA, busy, done, received byte, ACK sample) on the result side,
//   taken through empty/pop in input order. APB writes with paddr[2] low set
//   phase_ticks; the user must write it only while idle (unenforced).
// Timing:
//   A pushed word is stored in the input queue, handled combinationally by
//   the engine and stored in the result queue. While the result side has room
//   one word per cycle is sustained, one engine tick per single state update.
//   A command takes phase_ticks times its phase count (2, 3, 29 or 22) ticks.
// Reset:
//   Both queues empty, lines released, ACK hold one, phase_ticks 100.
// Stall:
//   When pop is held low the result queue fills, the engine holds its state,
//   then the input queue fills and full rises; no word is lost or repeated.
module i2c_bit_level_master_unit #(
  parameter int QUEUE_DEPTH = i2cbm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_cmd_valid,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_tx_byte,
  input  logic        in_send_nack,
  input  logic        in_sda_in,
  output logic        empty,
  input  logic        pop,
  output logic        out_scl_out,
  output logic        out_sda_out,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic [7:0]  out_rx_byte,
  output logic        out_ack_bit,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import i2cbm_pkg::*;

  logic [15:0]       phase_ticks_r;
  logic              cfg_wr;
  logic              iq_full, iq_empty, iq_wr, iq_rd;
  item_t             iq_wdata, iq_rdata;
  logic              rq_full, rq_wr;
  res_t              rq_wdata, rq_rdata;
  logic [ITEM_W-1:0] iq_rbits;
  logic [RES_W-1:0]  rq_rbits;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {16'd0, phase_ticks_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PHASE_TICKS_RST;
    end else if (cfg_wr) begin
      phase_ticks_r <= pwdata[15:0];
    end
  end

  i2cbm_front u_front (
    .push         (push),
    .full         (full),
    .in_cmd_valid (in_cmd_valid),
    .in_mode      (in_mode),
    .in_tx_byte   (in_tx_byte),
    .in_send_nack (in_send_nack),
    .in_sda_in    (in_sda_in),
    .q_full       (iq_full),
    .q_wr         (iq_wr),
    .q_item       (iq_wdata)
  );

  i2cbm_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_in_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (iq_wr),
    .wr_data (iq_wdata),
    .rd_en   (iq_rd),
    .rd_data (iq_rbits),
    .full    (iq_full),
    .empty   (iq_empty)
  );

  assign iq_rdata = item_t'(iq_rbits);

  i2cbm_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .phase_ticks (phase_ticks_r),
    .q_empty     (iq_empty),
    .q_item      (iq_rdata),
    .q_rd        (iq_rd),
    .r_full      (rq_full),
    .r_wr        (rq_wr),
    .r_res       (rq_wdata)
  );

  i2cbm_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (rq_wr),
    .wr_data (rq_wdata),
    .rd_en   (pop),
    .rd_data (rq_rbits),
    .full    (rq_full),
    .empty   (empty)
  );

  assign rq_rdata     = res_t'(rq_rbits);
  assign out_scl_out  = rq_rdata.scl;
  assign out_sda_out  = rq_rdata.sda;
  assign out_busy_res = rq_rdata.busy;
  assign out_done_res = rq_rdata.done;
  assign out_rx_byte  = rq_rdata.rx_byte;
  assign out_ack_bit  = rq_rdata.ack;

endmodule

@@ test/tb_i2c_bit_level_master_unit.sv @@
// testbench for the i2c bit-level master: tick stimulus, line prediction and result checks
module tb_i2c_bit_level_master_unit;
  import i2cbm_pkg::*;

  localparam logic [2:0] ADDR_PHASE_TICKS = 3'd0;
  localparam int SETTLE = 8;
  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD = 40;
  localparam int LONG_TICKS = 40;
  localparam int RAND_TICKS = 250;

  typedef enum {LINE_LOW, LINE_HIGH, LINE_RAND} sda_plan_t;

  class i2c_line_tracker;
    logic [15:0] period;
    mode_t       cur_mode;
    bit          engaged;
    logic [4:0]  phase_no;
    logic [15:0] tick_cnt;
    logic [7:0]  shifter;
    bit          nack_sel;
    bit          scl_lvl;
    bit          sda_lvl;
    logic [7:0]  rx_last;
    bit          ack_last;
    int          errors;
    res_t        expected_lines[$];
    byte unsigned phase_count[4];

    function new();
      period = PHASE_TICKS_RST;
      cur_mode = MODE_START;
      engaged = 0;
      phase_no = '0;
      tick_cnt = '0;
      shifter = '0;
      nack_sel = 0;
      scl_lvl = 1;
      sda_lvl = 1;
      rx_last = '0;
      ack_last = 1;
      errors = 0;
      phase_count = '{2, 3, 29, 22};
    endfunction

    function int pending();
      return expected_lines.size();
    endfunction

    task report(input string what);
      errors++;
      if (errors <= 40) $display("mismatch: %s", what);
    endtask

    function void step_phase(input bit sda);
      logic [4:0] p;
      p = phase_no;
      case (cur_mode)
        MODE_START: begin
          if (p == 0) begin
            sda_lvl = 1;
            scl_lvl = 1;
          end else sda_lvl = 0;
        end
        MODE_STOP: begin
          if (p == 0) sda_lvl = 0;
          else if (p == 1) scl_lvl = 1;
          else sda_lvl = 1;
        end
        MODE_WRITE: begin
          if (p < 24) begin
            case (p % 3)
              0: begin
                sda_lvl = shifter[7];
                scl_lvl = 0;
              end
              1: scl_lvl = 1;
              default: begin
                shifter = {shifter[6:0], 1'b0};
                scl_lvl = 0;
              end
            endcase
          end else if (p == 24) sda_lvl = 1;
          else if (p == 25) scl_lvl = 0;
          else if (p == 26) scl_lvl = 1;
          else if (p == 27) ack_last = sda;
          else scl_lvl = 0;
        end
        default: begin
          if (p == 0) sda_lvl = 1;
          else if (p == 1) scl_lvl = 0;
          else if (p < 18) begin
            if (!p[0]) scl_lvl = 1;
            else begin
              shifter = {shifter[6:0], sda};
              scl_lvl = 0;
            end
          end else if (p == 18) sda_lvl = nack_sel;
          else if (p == 19) scl_lvl = 1;
          else if (p == 20) scl_lvl = 0;
          else sda_lvl = 1;
        end
      endcase
    endfunction

    function void note_tick(input item_t t);
      logic [16:0] len;
      bit done;
      res_t r;
      len = (period == 0) ? 17'd1 : {1'b0, period};
      done = 0;
      if (engaged) begin
        if ({1'b0, tick_cnt} >= len) begin
          phase_no = phase_no + 5'd1;
          if (phase_no >= phase_count[cur_mode]) begin
            engaged = 0;
            done = 1;
            phase_no = '0;
            tick_cnt = '0;
            if (cur_mode == MODE_READ) rx_last = shifter;
          end else begin
            step_phase(t.sda_in);
            tick_cnt = 16'd1;
          end
        end else tick_cnt = tick_cnt + 16'd1;
      end else if (t.has_cmd) begin
        cur_mode = t.mode;
        engaged = 1;
        phase_no = '0;
        tick_cnt = 16'd1;
        shifter = (t.mode == MODE_WRITE) ? t.tx_byte : 8'h00;
        nack_sel = t.send_nack;
        step_phase(t.sda_in);
      end
      r.scl = scl_lvl;
      r.sda = sda_lvl;
      r.busy = engaged;
      r.done = done;
      r.rx_byte = rx_last;
      r.ack = ack_last;
      expected_lines.push_back(r);
    endfunction

    task check_word(input res_t got);
      res_t exp;
      if (expected_lines.size() == 0) begin
        report("result word with nothing expected");
      end else begin
        exp = expected_lines.pop_front();
        if (got.scl !== exp.scl)
          report($sformatf("scl_out got %b want %b", got.scl, exp.scl));
        if (got.sda !== exp.sda)
          report($sformatf("sda_out got %b want %b", got.sda, exp.sda));
        if (got.busy !== exp.busy)
          report($sformatf("busy_res got %b want %b", got.busy, exp.busy));
        if (got.done !== exp.done)
          report($sformatf("done_res got %b want %b", got.done, exp.done));
        if (got.rx_byte !== exp.rx_byte)
          report($sformatf("rx_byte got %h want %h", got.rx_byte, exp.rx_byte));
        if (got.ack !== exp.ack)
          report($sformatf("ack_bit got %b want %b", got.ack, exp.ack));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic        in_cmd_valid;
  logic [1:0]  in_mode;
  logic [7:0]  in_tx_byte;
  logic        in_send_nack;
  logic        in_sda_in;
  logic        empty;
  logic        pop;
  logic        out_scl_out;
  logic        out_sda_out;
  logic        out_busy_res;
  logic        out_done_res;
  logic [7:0]  out_rx_byte;
  logic        out_ack_bit;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  i2c_line_tracker sb;
  bit    steady;
  bit    stall_arm;
  mode_t last_mode;
  int    idle_cycles;

  i2c_bit_level_master_unit dut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full),
    .in_cmd_valid(in_cmd_valid), .in_mode(in_mode), .in_tx_byte(in_tx_byte),
    .in_send_nack(in_send_nack), .in_sda_in(in_sda_in),
    .empty(empty), .pop(pop),
    .out_scl_out(out_scl_out), .out_sda_out(out_sda_out), .out_busy_res(out_busy_res),
    .out_done_res(out_done_res), .out_rx_byte(out_rx_byte), .out_ack_bit(out_ack_bit),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_tick(input item_t t);
    if (!steady && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_cmd_valid <= t.has_cmd;
    in_mode <= t.mode;
    in_tx_byte <= t.tx_byte;
    in_send_nack <= t.send_nack;
    in_sda_in <= t.sda_in;
    push <= 1'b1;
    do @(posedge clk); while (full !== 1'b0);
    sb.note_tick(t);
  endtask

  task automatic run_cmd(input mode_t m, input logic [7:0] b, input bit nack,
                         input sda_plan_t plan, input bit noisy);
    item_t t;
    t.has_cmd = 1'b1;
    t.mode = m;
    t.tx_byte = b;
    t.send_nack = nack;
    t.sda_in = (plan == LINE_RAND) ? 1'($urandom) : (plan == LINE_HIGH);
    send_tick(t);
    while (sb.engaged) begin
      t.has_cmd = noisy;
      t.mode = mode_t'($urandom_range(0, 3));
      t.tx_byte = 8'($urandom);
      t.send_nack = 1'($urandom);
      t.sda_in = (plan == LINE_RAND) ? 1'($urandom) : (plan == LINE_HIGH);
      send_tick(t);
    end
  endtask

  function automatic item_t next_tick();
    item_t t;
    t.tx_byte = 8'($urandom);
    t.send_nack = 1'($urandom);
    t.sda_in = 1'($urandom);
    t.mode = mode_t'($urandom_range(0, 3));
    if (sb.engaged) begin
      t.has_cmd = ($urandom_range(0, 9) == 0);
    end else begin
      t.has_cmd = ($urandom_range(0, 3) != 0);
      if (t.has_cmd && $urandom_range(0, 6) != 0) begin
        case (last_mode)
          MODE_START: t.mode = MODE_WRITE;
          MODE_WRITE: t.mode = mode_t'($urandom_range(0, 3));
          MODE_READ:  t.mode = ($urandom_range(0, 2) == 0) ? MODE_STOP : MODE_READ;
          default:    t.mode = MODE_START;
        endcase
      end
      if (t.has_cmd) last_mode = t.mode;
    end
    return t;
  endfunction

  task automatic read_cfg();
    psel <= 1'b1;
    pwrite <= 1'b0;
    penable <= 1'b0;
    paddr <= ADDR_PHASE_TICKS;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata[15:0] !== sb.period)
      sb.report($sformatf("phase_ticks read %h want %h", prdata[15:0], sb.period));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_cfg(input logic [15:0] v);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_PHASE_TICKS;
    pwdata <= {16'h0000, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.period = v;
    read_cfg();
  endtask

  // result side
  initial begin
    int   hold_left;
    res_t got;
    hold_left = 0;
    pop = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        got.scl = out_scl_out;
        got.sda = out_sda_out;
        got.busy = out_busy_res;
        got.done = out_done_res;
        got.rx_byte = out_rx_byte;
        got.ack = out_ack_bit;
        sb.check_word(got);
      end
      if (stall_arm) begin
        stall_arm = 0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (!steady && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(0, 5);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty) || psel) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[i2c_bit_level_master_unit] ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] periods[4];
    item_t       first_tick;
    sb = new();
    rst_n = 1'b0;
    push = 1'b0;
    in_cmd_valid = 1'b0;
    in_mode = 2'b00;
    in_tx_byte = 8'h00;
    in_send_nack = 1'b0;
    in_sda_in = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    steady = 0;
    stall_arm = 0;
    last_mode = MODE_STOP;
    idle_cycles = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    read_cfg();

    // reset phase length
    run_cmd(MODE_START, 8'h00, 1'b0, LINE_RAND, 1'b0);
    run_cmd(MODE_STOP, 8'hFF, 1'b1, LINE_RAND, 1'b0);

    // shortest phases: every command, extreme bytes, ack and nack both ways
    write_cfg(16'd1);
    run_cmd(MODE_START, 8'h00, 1'b0, LINE_RAND, 1'b0);
    run_cmd(MODE_WRITE, 8'hFF, 1'b0, LINE_LOW, 1'b0);
    run_cmd(MODE_WRITE, 8'h00, 1'b1, LINE_HIGH, 1'b1);
    run_cmd(MODE_READ, 8'h00, 1'b0, LINE_HIGH, 1'b0);
    run_cmd(MODE_READ, 8'hFF, 1'b1, LINE_LOW, 1'b1);
    run_cmd(MODE_WRITE, 8'hA5, 1'b0, LINE_RAND, 1'b0);
    run_cmd(MODE_READ, 8'h5A, 1'b0, LINE_RAND, 1'b1);
    run_cmd(MODE_START, 8'h00, 1'b0, LINE_RAND, 1'b0);
    run_cmd(MODE_STOP, 8'h00, 1'b0, LINE_RAND, 1'b1);

    // zero length behaves as one tick
    write_cfg(16'd0);
    run_cmd(MODE_WRITE, 8'h3C, 1'b0, LINE_RAND, 1'b0);
    run_cmd(MODE_READ, 8'h00, 1'b1, LINE_RAND, 1'b1);

    // longest phases, cut short by the next period change
    write_cfg(16'hFFFF);
    first_tick = next_tick();
    first_tick.has_cmd = 1'b1;
    first_tick.mode = MODE_START;
    send_tick(first_tick);
    repeat (LONG_TICKS) send_tick(next_tick());

    periods = '{16'd2, 16'd3, 16'($urandom_range(4, 9)), 16'd1};
    for (int s = 0; s < 4; s++) begin
      write_cfg(periods[s]);
      if (s == 1) stall_arm = 1;
      for (int n = 0; n < RAND_TICKS; n++) begin
        if (s == 3 && n >= RAND_TICKS / 2) steady = 1;
        send_tick(next_tick());
      end
    end

    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[i2c_bit_level_master_unit] OK");
    end else begin
      $display("[i2c_bit_level_master_unit] ERROR");
    end
    $finish;
  end

endmodule
